/* rtl/mmcs_pkg.sv */
// Shared types and constants for the min/max contrast stretch block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package mmcs_pkg;

    localparam logic       KIND_LOAD  = 1'b0;
    localparam logic       KIND_FETCH = 1'b1;
    localparam logic [7:0] PIX_MAX    = 8'd255;
    localparam logic [2:0] DIV_LAST   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic mul;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fetch_err;
    } stat_t;

endpackage

/* rtl/mmcs_ctrl.sv */
// Sequencer for the contrast stretch: handshakes, fetch steps and divide count.
// Depends on mmcs_pkg.
`timescale 1ns / 1ps

module mmcs_ctrl
    import mmcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   kind,
    output logic   out_valid,
    input  logic   out_stall,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] div_cnt_reg;
    logic [2:0] div_cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        accept         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (accept && kind == KIND_LOAD)
                begin
                    cmd.load = 1'b1;
                end
                else if (accept && kind == KIND_FETCH)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = stat.fetch_err ? S_RESULT : S_READ;
                end
            end
            S_READ:
            begin
                // stored pixel is registered now; form the scaled offset
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/mmcs_dp.sv */
// Datapath: frame store, min/max tracking, pointers, scale and restoring divider.
// Depends on mmcs_pkg; driven by mmcs_ctrl commands.
`timescale 1ns / 1ps

module mmcs_dp
    import mmcs_pkg::*;
#(
    parameter int MAX_PIXELS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [7:0]  pixel,
    input  logic        last_pixel,
    output logic [7:0]  stretched,
    output logic        end_of_frame,
    output logic        fetch_error
);

    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [7:0]    mem [MAX_PIXELS];

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] rptr_reg;
    logic [CW-1:0] rptr_next;
    logic [CW-1:0] rptr_inc;
    logic [7:0]    lo_reg;
    logic [7:0]    lo_next;
    logic [7:0]    hi_reg;
    logic [7:0]    hi_next;
    logic          closed_reg;
    logic          closed_next;

    logic [CW-1:0] base_cnt;
    logic [7:0]    base_lo;
    logic [7:0]    base_hi;
    logic          room;

    logic [7:0]    rd_data_reg;
    logic          err_reg;
    logic          eof_reg;
    logic          zero_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    q_reg;
    logic [7:0]    stretched_reg;
    logic          eof_out_reg;
    logic          err_out_reg;

    logic [7:0]    off;
    logic [15:0]   prod;
    logic [8:0]    span9;
    logic [8:0]    trial;
    logic          ge;

    always_comb
    begin
        // a load after a closed frame opens a new one
        base_cnt = closed_reg ? '0 : cnt_reg;
        base_lo  = closed_reg ? PIX_MAX : lo_reg;
        base_hi  = closed_reg ? 8'd0 : hi_reg;
        room     = closed_reg || (cnt_reg < CW'(MAX_PIXELS));
        rptr_inc = rptr_reg + CW'(1);

        stat.fetch_err = !closed_reg || (rptr_reg >= cnt_reg);

        cnt_next    = cnt_reg;
        rptr_next   = rptr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        closed_next = closed_reg;
        if (cmd.load)
        begin
            cnt_next    = base_cnt;
            lo_next     = base_lo;
            hi_next     = base_hi;
            closed_next = last_pixel;
            if (closed_reg)
            begin
                rptr_next = '0;
            end
            if (room)
            begin
                cnt_next = base_cnt + CW'(1);
                if (pixel < base_lo)
                begin
                    lo_next = pixel;
                end
                if (pixel > base_hi)
                begin
                    hi_next = pixel;
                end
            end
        end
        else if (cmd.fetch && !stat.fetch_err)
        begin
            rptr_next = rptr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rptr_reg   <= '0;
            lo_reg     <= PIX_MAX;
            hi_reg     <= 8'd0;
            closed_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rptr_reg   <= rptr_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            closed_reg <= closed_next;
        end
    end

    // Frame store: one write port for loads, one registered read for fetches
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[base_cnt[AW-1:0]] <= pixel;
        end
        if (cmd.fetch && !stat.fetch_err)
        begin
            rd_data_reg <= mem[rptr_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        off   = rd_data_reg - lo_reg;
        prod  = {off, 8'd0} - {8'd0, off};
        span9 = {1'b0, hi_reg - lo_reg};
        trial = {rem_reg, q_reg[7]};
        ge    = (trial >= span9);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            err_reg <= stat.fetch_err;
            eof_reg <= (rptr_inc == cnt_reg);
        end
        if (cmd.mul)
        begin
            // quotient fits 8 bits, so start with the high byte as partial remainder
            zero_reg <= (hi_reg <= lo_reg) || (rd_data_reg < lo_reg);
            rem_reg  <= prod[15:8];
            q_reg    <= prod[7:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? 8'(trial - span9) : trial[7:0];
            q_reg   <= {q_reg[6:0], ge};
        end
        if (cmd.out_load)
        begin
            stretched_reg <= (err_reg || zero_reg) ? 8'd0 : q_reg;
            eof_out_reg   <= !err_reg && eof_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign stretched    = stretched_reg;
    assign end_of_frame = eof_out_reg;
    assign fetch_error  = err_out_reg;

endmodule

/* rtl/min_max_contrast_stretch.sv */
// Min/max contrast stretch top level: controller plus datapath.
// Load item: taken back to back, no result.
// Fetch item: read, scale, a spare state, 8-step divide and result load, in that
// order, into the output register; a fetch that errors goes straight to the result
// load. Input stalls until the result is loaded, so no item is taken before then.
// Reset (asynchronous, active low) empties the frame; the store itself is not cleared.
`timescale 1ns / 1ps

module min_max_contrast_stretch
    import mmcs_pkg::*;
#(
    parameter int MAX_PIXELS = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] pixel,
    input  logic       last_pixel,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] stretched,
    output logic       end_of_frame,
    output logic       fetch_error
);

    cmd_t  cmd;
    stat_t stat;

    mmcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mmcs_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .pixel        (pixel),
        .last_pixel   (last_pixel),
        .stretched    (stretched),
        .end_of_frame (end_of_frame),
        .fetch_error  (fetch_error)
    );

`ifndef SYNTHESIS
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fetch_error) |-> (stretched == 8'd0 && !end_of_frame))
        else $error("error item carries data");

    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_FETCH) |=> in_stall)
        else $error("input taken while a fetch is in progress");

    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without a fetch in progress");
`endif

endmodule
